>>> rtl/mrpt_pkg.sv
`default_nettype none
package mrpt_pkg;
  localparam int unsigned NumBases = 5;
  localparam int unsigned BaseTableSize = 12;
  localparam int unsigned BaseCount = (NumBases > BaseTableSize) ? BaseTableSize : NumBases;
  localparam int unsigned BaseIdxW = (BaseCount > 1) ? $clog2(BaseCount) : 1;

  localparam logic [63:0] PRIME_BASES [BaseTableSize] = '{
    64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13,
    64'd17, 64'd19, 64'd23, 64'd29, 64'd31, 64'd37
  };

  typedef enum logic [1:0] {
    MUL_ACC_SQ = 2'd0,
    MUL_SQ_SQ  = 2'd1,
    MUL_X_X    = 2'd2
  } mul_sel_t;

  typedef struct packed {
    logic     load_n;
    logic     shift_d;
    logic     load_base;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     shift_e;
    logic     acc_to_x;
  } mrpt_cmd_t;

  typedef struct packed {
    logic below_two;
    logic is_even;
    logic is_two;
    logic d_odd;
    logic r_more;
    logic base_zero;
    logic e_zero;
    logic e_lsb;
    logic mul_done;
    logic x_one;
    logic x_nm1;
  } mrpt_status_t;
endpackage
`default_nettype wire

>>> rtl/mrpt_if.sv
`default_nettype none
interface mrpt_cand_if;
  logic        valid;
  logic        ready;
  logic [63:0] candidate;
  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

interface mrpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;
  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface
`default_nettype wire

>>> rtl/mrpt_mulmod.sv
`default_nettype none
module mrpt_mulmod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] x,
  input  wire logic [63:0] y,
  input  wire logic [63:0] m,
  output logic             done,
  output logic [63:0]      result
);
  logic [63:0] xr;
  logic [63:0] yr;
  logic [6:0]  cnt;
  logic        busy;
  logic [63:0] dbl;
  logic [63:0] sum;

  function automatic logic [63:0] add_mod(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] md);
    logic [63:0] room;
    room = md - b;
    return (a >= room) ? (a - room) : (a + b);
  endfunction

  assign dbl = add_mod(result, result, m);
  assign sum = yr[63] ? add_mod(dbl, xr, m) : dbl;

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      xr <= x;
      yr <= y;
      result <= '0;
      cnt <= 7'd64;
    end else if (busy) begin
      result <= sum;
      yr <= {yr[62:0], 1'b0};
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/mrpt_datapath.sv
`default_nettype none
module mrpt_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic [63:0]          candidate,
  input  wire logic [mrpt_pkg::BaseIdxW-1:0] base_idx,
  input  wire mrpt_pkg::mrpt_cmd_t  cmd,
  output mrpt_pkg::mrpt_status_t    status
);
  logic [63:0] n;
  logic [63:0] d;
  logic [63:0] e;
  logic [63:0] acc;
  logic [63:0] sq;
  logic [63:0] x;
  logic [6:0]  r;
  logic [6:0]  rcnt;
  logic [63:0] a;
  logic [63:0] mx;
  logic [63:0] my;
  logic [63:0] mres;
  logic        mdone;
  logic [63:0] base;

  assign base = mrpt_pkg::PRIME_BASES[base_idx];
  // n is odd and at least 3 here; a is base, or base - n when base is at least n
  assign a = (base >= n) ? (base - n) : base;

  always_comb begin
    case (cmd.mul_sel)
      mrpt_pkg::MUL_ACC_SQ: begin mx = acc; my = sq; end
      mrpt_pkg::MUL_SQ_SQ:  begin mx = sq;  my = sq; end
      default:              begin mx = x;   my = x; end
    endcase
  end

  mrpt_mulmod u_mul (
    .clk(clk), .rst(rst), .start(cmd.mul_start), .x(mx), .y(my), .m(n),
    .done(mdone), .result(mres)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_n) begin
      n <= candidate;
      d <= candidate - 64'd1;
      r <= '0;
    end
    if (cmd.shift_d) begin
      d <= d >> 1;
      r <= r + 7'd1;
    end
    if (cmd.load_base) begin
      e <= d;
      acc <= 64'd1;
      sq <= a;
      rcnt <= 7'd1;
    end
    if (cmd.shift_e) e <= e >> 1;
    if (mdone) begin
      case (cmd.mul_sel)
        mrpt_pkg::MUL_ACC_SQ: acc <= mres;
        mrpt_pkg::MUL_SQ_SQ:  sq <= mres;
        default: begin
          x <= mres;
          rcnt <= rcnt + 7'd1;
        end
      endcase
    end
    if (cmd.acc_to_x) x <= acc;
  end

  assign status.below_two = (n < 64'd2);
  assign status.is_even   = ~n[0];
  assign status.is_two    = (n == 64'd2);
  assign status.d_odd     = d[0];
  assign status.r_more    = (rcnt < r);
  assign status.base_zero = (base == n);
  assign status.e_zero    = (e == 64'd0);
  assign status.e_lsb     = e[0];
  assign status.mul_done  = mdone;
  assign status.x_one     = (x == 64'd1);
  assign status.x_nm1     = (x == n - 64'd1);
endmodule
`default_nettype wire

>>> rtl/mrpt_ctrl.sv
`default_nettype none
module mrpt_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_flag,
  output logic [mrpt_pkg::BaseIdxW-1:0] base_idx,
  output mrpt_pkg::mrpt_cmd_t       cmd,
  input  wire mrpt_pkg::mrpt_status_t status
);
  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_SPLIT, S_BASE, S_EXP, S_MUL_ACC, S_MUL_SQ,
    S_TEST, S_SQR, S_SQR_CHK, S_NEXT, S_DONE
  } state_t;

  state_t state;
  logic   busy_mul;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    cmd = '0;
    cmd.mul_sel = mrpt_pkg::MUL_X_X;
    case (state)
      S_IDLE:    cmd.load_n = in_valid && in_ready;
      S_SPLIT:   cmd.shift_d = !status.d_odd;
      S_BASE:    cmd.load_base = !status.base_zero;
      S_MUL_ACC: begin
        cmd.mul_sel = mrpt_pkg::MUL_ACC_SQ;
        cmd.mul_start = !busy_mul;
      end
      S_MUL_SQ: begin
        cmd.mul_sel = mrpt_pkg::MUL_SQ_SQ;
        cmd.mul_start = !busy_mul;
        cmd.shift_e = status.mul_done;
      end
      S_EXP:     cmd.acc_to_x = status.e_zero;
      S_SQR:     cmd.mul_start = !busy_mul;
      default:   cmd.mul_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      out_flag <= 1'b0;
      base_idx <= '0;
      busy_mul <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.mul_start) busy_mul <= 1'b1;
      if (status.mul_done) busy_mul <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) state <= S_CHECK;
        S_CHECK: begin
          base_idx <= '0;
          if (status.below_two) begin
            out_flag <= 1'b0; state <= S_DONE;
          end else if (status.is_even) begin
            out_flag <= status.is_two; state <= S_DONE;
          end else state <= S_SPLIT;
        end
        S_SPLIT: if (status.d_odd) state <= S_BASE;
        S_BASE: begin
          if (status.base_zero) begin
            out_flag <= 1'b1; state <= S_DONE;
          end else state <= S_EXP;
        end
        S_EXP: begin
          if (status.e_zero) state <= S_TEST;
          else if (status.e_lsb) state <= S_MUL_ACC;
          else state <= S_MUL_SQ;
        end
        S_MUL_ACC: if (status.mul_done) state <= S_MUL_SQ;
        S_MUL_SQ:  if (status.mul_done) state <= S_EXP;
        S_TEST: begin
          if (status.x_one || status.x_nm1) state <= S_NEXT;
          else if (status.r_more) state <= S_SQR;
          else begin
            out_flag <= 1'b0; state <= S_DONE;
          end
        end
        S_SQR: if (status.mul_done) state <= S_SQR_CHK;
        S_SQR_CHK: begin
          if (status.x_nm1) state <= S_NEXT;
          else if (status.r_more) state <= S_SQR;
          else begin
            out_flag <= 1'b0; state <= S_DONE;
          end
        end
        S_NEXT: begin
          if (base_idx == mrpt_pkg::BaseIdxW'(mrpt_pkg::BaseCount - 1)) begin
            out_flag <= 1'b1; state <= S_DONE;
          end else begin
            base_idx <= base_idx + 1'b1; state <= S_BASE;
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_done_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) |=> out_valid) else $error("result lost");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.mul_start |-> !busy_mul) else $error("multiplier restarted");
endmodule
`default_nettype wire

>>> rtl/miller_rabin_prime_test.sv
// channel   dir  payload            handshake
// cand      in   candidate[63:0]    valid/ready
// res       out  is_prime           valid/ready
// one candidate at a time; each modular product holds the controller in the
// shared shift-and-add unit, up to 126 products per base
// rejected trivial cases go from S_CHECK straight to S_DONE, which raises the valid result
// rst is synchronous and clears the controller; the result waits until taken
// a new candidate is taken only once the previous result has been delivered
`default_nettype none
module miller_rabin_prime_test (
  input  wire logic clk,
  input  wire logic rst,
  mrpt_cand_if.sink cand,
  mrpt_res_if.source res
);
  mrpt_pkg::mrpt_cmd_t    cmd;
  mrpt_pkg::mrpt_status_t status;
  logic [mrpt_pkg::BaseIdxW-1:0] base_idx;

  mrpt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(cand.valid), .in_ready(cand.ready),
    .out_valid(res.valid), .out_ready(res.ready), .out_flag(res.is_prime),
    .base_idx(base_idx), .cmd(cmd), .status(status)
  );

  mrpt_datapath u_dp (
    .clk(clk), .rst(rst), .candidate(cand.candidate), .base_idx(base_idx),
    .cmd(cmd), .status(status)
  );
endmodule
`default_nettype wire

>>> test/miller_rabin_prime_test_test.sv
`default_nettype none
module miller_rabin_prime_test_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mrpt_cand_if cand ();
  mrpt_res_if res ();

  miller_rabin_prime_test dut (
    .clk(clk),
    .rst(rst),
    .cand(cand.sink),
    .res(res.source)
  );

  always #10 clk = ~clk;

  logic [63:0] pending_cands[$];
  bit          expected_flags[$];
  logic [63:0] expected_cands[$];
  int          mismatches = 0;
  int          unexpected = 0;
  int          checked = 0;
  int          primes_seen = 0;
  bit          timid_sender = 1'b1;
  bit          timid_receiver = 1'b1;

  function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [63:0] pow_mod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1 % m;
    sq = b % m;
    while (e != 64'd0) begin
      if (e[0]) acc = mul_mod(acc, sq, m);
      sq = mul_mod(sq, sq, m);
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic bit strong_probable_prime(logic [63:0] n);
    logic [63:0] nm1;
    logic [63:0] d;
    logic [63:0] a;
    logic [63:0] x;
    int          r;
    bit          hit;
    if (n < 64'd2) return 1'b0;
    if (!n[0]) return n == 64'd2;
    nm1 = n - 64'd1;
    d = nm1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    for (int i = 0; i < mrpt_pkg::BaseCount; i++) begin
      a = mrpt_pkg::PRIME_BASES[i] % n;
      if (a == 64'd0) return 1'b1;
      x = pow_mod(a, d, n);
      if (x == 64'd1 || x == nm1) continue;
      hit = 1'b0;
      for (int j = 1; j < r; j++) begin
        x = mul_mod(x, x, n);
        if (x == nm1) begin
          hit = 1'b1;
          break;
        end
      end
      if (!hit) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int draw_gap(bit timid);
    if (!timid) return 0;
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 4);
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      cand.valid <= 1'b0;
      cand.candidate <= 64'd0;
      send_gap <= 0;
    end else begin
      if (cand.valid && cand.ready) begin
        expected_flags.push_back(strong_probable_prime(cand.candidate));
        expected_cands.push_back(cand.candidate);
      end
      if (!cand.valid || cand.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          cand.valid <= 1'b0;
        end else if (pending_cands.size() > 0) begin
          cand.valid <= 1'b1;
          cand.candidate <= pending_cands.pop_front();
          send_gap <= draw_gap(timid_sender);
        end else begin
          cand.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int hold = 0;
  always @(posedge clk) begin
    int next_hold;
    bit want;
    logic [63:0] n;
    if (rst) begin
      res.ready <= 1'b0;
      hold <= 0;
    end else begin
      next_hold = (hold > 0) ? hold - 1 : 0;
      if (res.valid && res.ready) begin
        if (expected_flags.size() == 0) begin
          unexpected++;
          if (mismatches + unexpected <= 10)
            $display("ERROR: result is_prime=%0b with no transaction outstanding", res.is_prime);
        end else begin
          want = expected_flags.pop_front();
          n = expected_cands.pop_front();
          checked++;
          if (want) primes_seen++;
          if (res.is_prime !== want) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("ERROR: candidate %0d expected is_prime=%0b got %0b",
                       n, want, res.is_prime);
          end
        end
        next_hold = draw_gap(timid_receiver);
      end
      hold <= next_hold;
      res.ready <= (next_hold == 0);
    end
  end

  initial begin
    #500_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_candidate();
    int kind;
    int w;
    logic [63:0] v;
    kind = $urandom_range(0, 99);
    w = $urandom_range(2, 28);
    v = rand64();
    if (kind < 55) return (v & ((64'd1 << w) - 64'd1)) | 64'd1;
    if (kind < 70) return {$urandom_range(1, 4095), $urandom_range(1, 65535)} * 64'd1 | 64'd1;
    if (kind < 80) return v | 64'd1;
    if (kind < 90) return v;
    if (kind < 95) return 64'($urandom_range(0, 40));
    return v & ~64'd1;
  endfunction

  initial begin
    cand.valid = 1'b0;
    cand.candidate = 64'd0;
    res.ready = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // edge values, bases themselves, known strong pseudoprimes, largest 64-bit prime
    pending_cands = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd7, 64'd11, 64'd9,
                      64'd13, 64'd561, 64'd2047, 64'd1373653, 64'd25326001,
                      64'd3215031751, 64'd2152302898747, 64'd3474749660383,
                      64'd3825123056546413051, 64'hFFFF_FFFF_FFFF_FFFF,
                      64'hFFFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000,
                      64'd18446744073709551557, 64'd4294967291};
    for (int i = 0; i < 100; i++) begin
      if (i % 20 == 0) begin
        timid_sender = $urandom_range(0, 3) != 0;
        timid_receiver = $urandom_range(0, 3) != 0;
      end
      pending_cands.push_back(random_candidate());
    end

    while (pending_cands.size() > 0 || cand.valid || expected_flags.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("checked %0d results (%0d probable primes), %0d mismatches, %0d unexpected",
             checked, primes_seen, mismatches, unexpected);
    if (mismatches == 0 && unexpected == 0 && expected_flags.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> sim.f
rtl/mrpt_pkg.sv
rtl/mrpt_if.sv
rtl/mrpt_mulmod.sv
rtl/mrpt_datapath.sv
rtl/mrpt_ctrl.sv
rtl/miller_rabin_prime_test.sv
test/miller_rabin_prime_test_test.sv
